@@ rtl/dets_pkg.sv @@
// Package for the dual envelope transient shaper: widths, fixed point constants,
// payload structs, configuration register indexes, sequencer states and MAC control.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dets_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int CHANNELS_DEF = 8;
    localparam int CH_W         = 3;
    localparam int COEF_W       = 24;
    localparam int AMT_W        = 16;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    localparam int ENV_W   = SAMPLE_BITS + 16;
    localparam int LO_BITS = 24;
    localparam int HI_BITS = ENV_W - LO_BITS;

    localparam int A_W = (SAMPLE_BITS > LO_BITS) ? SAMPLE_BITS : LO_BITS + 1;
    localparam int B_W = COEF_W + 2;
    localparam int P_W = A_W + B_W;

    localparam int ATT_SHIFT = SAMPLE_BITS + 13 - LO_BITS;
    localparam int SUS_SHIFT = SAMPLE_BITS + 14 - LO_BITS;
    localparam int Y_SHIFT   = 16;

    localparam int GAIN_W = 22;

    localparam logic [COEF_W:0] COEF_ONE = {1'b1, {COEF_W{1'b0}}};

    localparam logic [COEF_W-1:0] FAST_COEFF_RST = COEF_W'(16742302);
    localparam logic [COEF_W-1:0] SLOW_COEFF_RST = COEF_W'(16773721);

    localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = GAIN_W'(6554);
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = GAIN_W'(262144);

    localparam logic signed [P_W-1:0] ROUND_HALF = P_W'(32768);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_in;
        logic [CH_W-1:0]               channel;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [CH_W-1:0]               channel_out;
    } t_out;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAST_COEFF,
        CFG_SLOW_COEFF,
        CFG_ATTACK_AMOUNT,
        CFG_SUSTAIN_AMOUNT
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FLO,
        S_FHI,
        S_FMLO,
        S_FMHI,
        S_SLO,
        S_SHI,
        S_SMLO,
        S_SMHI,
        S_TDIFF,
        S_TLO,
        S_THI,
        S_ULO,
        S_UHI,
        S_GAIN,
        S_YMUL,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        MAC_LOW,
        MAC_HIGH,
        MAC_ROUND
    } t_mac_op;

    typedef struct packed {
        logic    en;
        t_mac_op op;
    } t_mac_ctl;

endpackage

`default_nettype wire

@@ rtl/dets_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dets_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/dets_mac.sv @@
// Shared signed multiply-accumulate unit of the transient shaper.
// Depends on dets_pkg for widths and the MAC control struct.
`timescale 1ns / 1ps
`default_nettype none

module dets_mac (
    input  wire logic                               i_clk,
    input  wire dets_pkg::t_mac_ctl                 i_ctl,
    input  wire logic signed [dets_pkg::A_W-1:0]    i_a,
    input  wire logic signed [dets_pkg::B_W-1:0]    i_b,
    output logic signed      [dets_pkg::P_W-1:0]    o_acc
);

    logic signed [dets_pkg::P_W-1:0] prod;
    logic signed [dets_pkg::P_W-1:0] r_acc;
    logic signed [dets_pkg::P_W-1:0] n_acc;

    assign prod = i_a * i_b;

    always_comb begin
        unique case (i_ctl.op)
            dets_pkg::MAC_LOW:   n_acc = prod >>> dets_pkg::LO_BITS;
            dets_pkg::MAC_HIGH:  n_acc = r_acc + prod;
            dets_pkg::MAC_ROUND: n_acc = prod + dets_pkg::ROUND_HALF;
            default:             n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

@@ rtl/dual_envelope_transient_shaper.sv @@
// A request is accepted only while the sequencer is idle; one shared MAC runs 13 passes per sample.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (synchronous, active low) clears the sequencer, the per-channel envelope
// valid bits (envelopes read as zero until written) and loads the register defaults.
// Depends on dets_pkg, dets_ram and dets_mac.
`timescale 1ns / 1ps
`default_nettype none

module dual_envelope_transient_shaper #(
    parameter int CHANNELS = dets_pkg::CHANNELS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire dets_pkg::t_in                     i_data,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output dets_pkg::t_out                         o_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [dets_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dets_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SB    = dets_pkg::SAMPLE_BITS;
    localparam int EW    = dets_pkg::ENV_W;
    localparam int LB    = dets_pkg::LO_BITS;
    localparam int AW    = dets_pkg::A_W;
    localparam int BW    = dets_pkg::B_W;
    localparam int PW    = dets_pkg::P_W;
    localparam int GW    = dets_pkg::GAIN_W;
    localparam int CF_W  = dets_pkg::COEF_W;
    localparam int AMT_W = dets_pkg::AMT_W;

    function automatic logic [CW-1:0] ch_index(input logic [dets_pkg::CH_W-1:0] ch);
        logic [dets_pkg::CH_W:0] v;
        v = {1'b0, ch};
        for (int k = 0; k < (1 << dets_pkg::CH_W); k++) begin
            if (int'(v) >= CHANNELS) begin
                v = v - (dets_pkg::CH_W + 1)'(CHANNELS);
            end
        end
        return CW'(v);
    endfunction

    dets_pkg::t_state r_state;
    dets_pkg::t_state n_state;

    logic signed [SB-1:0]           r_x;
    logic [dets_pkg::CH_W-1:0]      r_ch;
    logic [CW-1:0]                  r_idx;
    logic                           r_hit;
    logic [CHANNELS-1:0]            r_vld;
    logic [CF_W-1:0]                r_fast_c;
    logic [CF_W-1:0]                r_slow_c;
    logic signed [AMT_W-1:0]        r_att_amt;
    logic signed [AMT_W-1:0]        r_sus_amt;
    logic [EW-1:0]                  r_part;
    logic [EW-1:0]                  r_fenv;
    logic [EW-1:0]                  r_senv;
    logic signed [GW-1:0]           r_att;
    logic signed [GW-1:0]           r_gain;
    dets_pkg::t_out                 r_out;
    logic                           r_ovalid;

    logic                           in_acc;
    logic                           out_free;
    logic [CW-1:0]                  in_idx;
    logic [2*EW-1:0]                ram_rdata;
    logic                           ram_we;
    logic [EW-1:0]                  env_f;
    logic [EW-1:0]                  env_s;
    logic [SB-1:0]                  mag_abs;
    logic [EW-1:0]                  mag;
    logic [CF_W:0]                  fast_cm;
    logic [CF_W:0]                  slow_cm;
    logic signed [EW:0]             t_diff;
    logic                           t_pos;
    logic [EW-1:0]                  t_mag;
    logic signed [PW-1:0]           mac_acc;
    logic signed [AW-1:0]           mac_a;
    logic signed [BW-1:0]           mac_b;
    dets_pkg::t_mac_ctl             mac_ctl;
    logic [EW-1:0]                  env_sum;
    logic signed [GW-1:0]           sus_term;
    logic signed [GW-1:0]           gain_sum;
    logic signed [GW-1:0]           gain_clamped;
    logic signed [PW-1:0]           y_sh;
    logic                           y_ovf;
    logic signed [SB-1:0]           y_sat;

    assign o_ready     = (r_state == dets_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_ovalid || i_ready;
    assign in_idx      = ch_index(i_data.channel);

    assign env_f   = r_hit ? ram_rdata[2*EW-1:EW] : '0;
    assign env_s   = r_hit ? ram_rdata[EW-1:0] : '0;
    assign mag_abs = r_x[SB-1] ? (~SB'(r_x) + SB'(1)) : SB'(r_x);
    assign mag     = {mag_abs, {(EW - SB){1'b0}}};
    assign fast_cm = dets_pkg::COEF_ONE - {1'b0, r_fast_c};
    assign slow_cm = dets_pkg::COEF_ONE - {1'b0, r_slow_c};
    assign t_diff  = $signed({1'b0, r_fenv}) - $signed({1'b0, r_senv});
    assign t_pos   = !t_diff[EW] && (t_diff != '0);
    assign t_mag   = t_pos ? t_diff[EW-1:0] : '0;
    assign env_sum = r_part + mac_acc[EW-1:0];

    assign sus_term = GW'(mac_acc >>> dets_pkg::SUS_SHIFT);
    assign gain_sum = dets_pkg::GAIN_ONE + r_att + sus_term;

    always_comb begin
        priority if (gain_sum < dets_pkg::GAIN_MIN) begin
            gain_clamped = dets_pkg::GAIN_MIN;
        end else if (gain_sum > dets_pkg::GAIN_MAX) begin
            gain_clamped = dets_pkg::GAIN_MAX;
        end else begin
            gain_clamped = gain_sum;
        end
    end

    assign y_sh  = mac_acc >>> dets_pkg::Y_SHIFT;
    assign y_ovf = (y_sh[PW-1:SB-1] != '0) && (y_sh[PW-1:SB-1] != '1);
    assign y_sat = y_ovf ? (y_sh[PW-1] ? {1'b1, {(SB - 1){1'b0}}} : {1'b0, {(SB - 1){1'b1}}})
                         : y_sh[SB-1:0];

    dets_ram #(
        .WIDTH (2 * EW),
        .DEPTH (CHANNELS)
    ) u_env_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata ({r_fenv, r_senv}),
        .i_re    (in_acc),
        .i_raddr (in_idx),
        .o_rdata (ram_rdata)
    );

    dets_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (mac_acc)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dets_pkg::S_IDLE:  if (i_valid) n_state = dets_pkg::S_FLO;
            dets_pkg::S_FLO:   n_state = dets_pkg::S_FHI;
            dets_pkg::S_FHI:   n_state = dets_pkg::S_FMLO;
            dets_pkg::S_FMLO:  n_state = dets_pkg::S_FMHI;
            dets_pkg::S_FMHI:  n_state = dets_pkg::S_SLO;
            dets_pkg::S_SLO:   n_state = dets_pkg::S_SHI;
            dets_pkg::S_SHI:   n_state = dets_pkg::S_SMLO;
            dets_pkg::S_SMLO:  n_state = dets_pkg::S_SMHI;
            dets_pkg::S_SMHI:  n_state = dets_pkg::S_TDIFF;
            dets_pkg::S_TDIFF: n_state = dets_pkg::S_TLO;
            dets_pkg::S_TLO:   n_state = dets_pkg::S_THI;
            dets_pkg::S_THI:   n_state = dets_pkg::S_ULO;
            dets_pkg::S_ULO:   n_state = dets_pkg::S_UHI;
            dets_pkg::S_UHI:   n_state = dets_pkg::S_GAIN;
            dets_pkg::S_GAIN:  n_state = dets_pkg::S_YMUL;
            dets_pkg::S_YMUL:  n_state = dets_pkg::S_OUT;
            dets_pkg::S_OUT:   if (out_free) n_state = dets_pkg::S_IDLE;
            default:           n_state = dets_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        mac_ctl = '{en: 1'b0, op: dets_pkg::MAC_LOW};
        mac_a   = '0;
        mac_b   = '0;
        ram_we  = 1'b0;
        unique case (r_state)
            dets_pkg::S_FLO: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_LOW};
                mac_a   = AW'(env_f[LB-1:0]);
                mac_b   = BW'(r_fast_c);
            end
            dets_pkg::S_FHI: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_HIGH};
                mac_a   = AW'(env_f[EW-1:LB]);
                mac_b   = BW'(r_fast_c);
            end
            dets_pkg::S_FMLO: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_LOW};
                mac_a   = AW'(mag[LB-1:0]);
                mac_b   = BW'(fast_cm);
            end
            dets_pkg::S_FMHI: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_HIGH};
                mac_a   = AW'(mag[EW-1:LB]);
                mac_b   = BW'(fast_cm);
            end
            dets_pkg::S_SLO: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_LOW};
                mac_a   = AW'(env_s[LB-1:0]);
                mac_b   = BW'(r_slow_c);
            end
            dets_pkg::S_SHI: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_HIGH};
                mac_a   = AW'(env_s[EW-1:LB]);
                mac_b   = BW'(r_slow_c);
            end
            dets_pkg::S_SMLO: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_LOW};
                mac_a   = AW'(mag[LB-1:0]);
                mac_b   = BW'(slow_cm);
            end
            dets_pkg::S_SMHI: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_HIGH};
                mac_a   = AW'(mag[EW-1:LB]);
                mac_b   = BW'(slow_cm);
            end
            dets_pkg::S_TLO: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_LOW};
                mac_a   = AW'(t_mag[LB-1:0]);
                mac_b   = BW'(r_att_amt);
                ram_we  = 1'b1;
            end
            dets_pkg::S_THI: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_HIGH};
                mac_a   = AW'(t_mag[EW-1:LB]);
                mac_b   = BW'(r_att_amt);
            end
            dets_pkg::S_ULO: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_LOW};
                mac_a   = AW'(r_senv[LB-1:0]);
                mac_b   = BW'(r_sus_amt);
            end
            dets_pkg::S_UHI: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_HIGH};
                mac_a   = AW'(r_senv[EW-1:LB]);
                mac_b   = BW'(r_sus_amt);
            end
            dets_pkg::S_YMUL: begin
                mac_ctl = '{en: 1'b1, op: dets_pkg::MAC_ROUND};
                mac_a   = AW'(r_x);
                mac_b   = BW'(r_gain);
            end
            dets_pkg::S_IDLE, dets_pkg::S_TDIFF, dets_pkg::S_GAIN, dets_pkg::S_OUT: begin
                mac_ctl = '{en: 1'b0, op: dets_pkg::MAC_LOW};
            end
            default: begin
                mac_ctl = '{en: 1'b0, op: dets_pkg::MAC_LOW};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dets_pkg::S_IDLE;
            r_vld     <= '0;
            r_ovalid  <= 1'b0;
            r_fast_c  <= dets_pkg::FAST_COEFF_RST;
            r_slow_c  <= dets_pkg::SLOW_COEFF_RST;
            r_att_amt <= '0;
            r_sus_amt <= '0;
        end else begin
            r_state <= n_state;
            if (ram_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            if (r_state == dets_pkg::S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (dets_pkg::t_cfg_idx'(i_cfg_index))
                    dets_pkg::CFG_FAST_COEFF:     r_fast_c  <= i_cfg_data[CF_W-1:0];
                    dets_pkg::CFG_SLOW_COEFF:     r_slow_c  <= i_cfg_data[CF_W-1:0];
                    dets_pkg::CFG_ATTACK_AMOUNT:  r_att_amt <= i_cfg_data[AMT_W-1:0];
                    dets_pkg::CFG_SUSTAIN_AMOUNT: r_sus_amt <= i_cfg_data[AMT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x   <= i_data.sample_in;
            r_ch  <= i_data.channel;
            r_idx <= in_idx;
            r_hit <= r_vld[in_idx];
        end
        unique case (r_state)
            dets_pkg::S_FMLO, dets_pkg::S_SMLO: r_part <= mac_acc[EW-1:0];
            dets_pkg::S_SLO:   r_fenv <= env_sum;
            dets_pkg::S_TDIFF: r_senv <= env_sum;
            dets_pkg::S_ULO:   r_att  <= GW'(mac_acc >>> dets_pkg::ATT_SHIFT);
            dets_pkg::S_GAIN:  r_gain <= gain_clamped;
            dets_pkg::S_OUT: begin
                if (out_free) begin
                    r_out.sample_out  <= y_sat;
                    r_out.channel_out <= r_ch;
                end
            end
            default: ;
        endcase
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == dets_pkg::S_FLO))
        else $error("accepted request did not start the sequencer");

    a_gain_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dets_pkg::S_YMUL) |->
            (r_gain >= dets_pkg::GAIN_MIN) && (r_gain <= dets_pkg::GAIN_MAX))
        else $error("gain out of clamp range");

    a_env_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_vld[r_idx])
        else $error("envelope write did not mark channel valid");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == dets_pkg::S_OUT))
        else $error("result appeared outside output state");
`endif

endmodule

`default_nettype wire

@@ tb/dual_envelope_transient_shaper_tb.sv @@
// Testbench for dual_envelope_transient_shaper: directed and random sample requests checked
// against an in-bench envelope follower and gain predictor over several register settings.
// Depends on dets_pkg and the block's RTL.
`timescale 1ns / 1ps

module dual_envelope_transient_shaper_tb;
    import dets_pkg::*;

    localparam int     N_CH        = 8;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     SETTLE      = 20;
    localparam longint S_MAX       = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint S_MIN       = -(longint'(1) << (SAMPLE_BITS - 1));

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    t_in                   i_data      = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    t_out                  o_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic [ENV_W-1:0]        fast_env [N_CH];
    logic [ENV_W-1:0]        slow_env [N_CH];
    logic [COEF_W-1:0]       fast_pole   = FAST_COEFF_RST;
    logic [COEF_W-1:0]       slow_pole   = SLOW_COEFF_RST;
    logic signed [AMT_W-1:0] attack_amt  = '0;
    logic signed [AMT_W-1:0] sustain_amt = '0;

    t_in  request_q [$];
    t_out shaped_q [$];
    t_out want;

    int items_total     = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int errors          = 0;
    int cycles          = 0;
    int tx_idle_pct     = 0;
    int rx_stall_pct    = 0;
    int rx_hold_left    = 0;
    bit tx_pause        = 1'b0;

    dual_envelope_transient_shaper dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [ENV_W-1:0] follow_env(input logic [ENV_W-1:0] env,
                                                    input logic [ENV_W-1:0] mag,
                                                    input logic [COEF_W-1:0] pole);
        logic [ENV_W+COEF_W:0] held;
        logic [ENV_W+COEF_W:0] fresh;
        held  = env * pole;
        fresh = mag * (COEF_ONE - pole);
        return ENV_W'((held >> COEF_W) + (fresh >> COEF_W));
    endfunction

    function automatic t_out predict_shaped(input t_in req);
        logic [ENV_W-1:0] mag;
        logic [ENV_W-1:0] f;
        logic [ENV_W-1:0] s;
        longint           x;
        longint           t;
        longint           gain;
        longint           y;
        int               idx;
        t_out             r;
        x    = $signed(req.sample_in);
        idx  = req.channel % N_CH;
        mag  = ENV_W'((x < 0 ? -x : x) << 16);
        f    = follow_env(fast_env[idx], mag, fast_pole);
        s    = follow_env(slow_env[idx], mag, slow_pole);
        fast_env[idx] = f;
        slow_env[idx] = s;
        t    = longint'(f) - longint'(s);
        gain = GAIN_ONE;
        if (t > 0) begin
            gain += (t * longint'(attack_amt)) >>> (ENV_W - 3);
        end
        gain += (longint'(s) * longint'(sustain_amt)) >>> (ENV_W - 2);
        if (gain < GAIN_MIN) gain = GAIN_MIN;
        if (gain > GAIN_MAX) gain = GAIN_MAX;
        y = (x * gain + 32768) >>> 16;
        if (y < S_MIN) y = S_MIN;
        if (y > S_MAX) y = S_MAX;
        r.sample_out  = y[SAMPLE_BITS-1:0];
        r.channel_out = req.channel;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input int mode, input int j);
        int amp;
        bit neg;
        amp = 0;
        neg = $urandom_range(0, 1);
        case (mode)
            0, 6: return SAMPLE_BITS'($urandom);
            1: amp = $urandom_range(6000000, 8388607);
            2: amp = $urandom_range(0, 2047);
            3: begin
                case ($urandom_range(0, 3))
                    0: return SAMPLE_BITS'(S_MAX);
                    1: return SAMPLE_BITS'(S_MIN);
                    2: return '0;
                    default: return '1;
                endcase
            end
            4: amp = (j < 24) ? (8388607 >> j) : 0;
            default: amp = 0;
        endcase
        return neg ? SAMPLE_BITS'(-amp) : SAMPLE_BITS'(amp);
    endfunction

    function automatic logic [COEF_W-1:0] random_pole();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return COEF_W'($urandom);
            default: return COEF_W'(24'hFFFFFF - $urandom_range(0, 65536));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_amount();
        logic [AMT_W-1:0] a;
        case ($urandom_range(0, 3))
            0: a = 16'h8000;
            1: a = 16'h7FFF;
            default: a = AMT_W'($urandom);
        endcase
        return {(CFG_DATA_W - AMT_W)'($urandom), a};
    endfunction

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_FAST_COEFF:     fast_pole   = val[COEF_W-1:0];
            CFG_SLOW_COEFF:     slow_pole   = val[COEF_W-1:0];
            CFG_ATTACK_AMOUNT:  attack_amt  = val[AMT_W-1:0];
            CFG_SUSTAIN_AMOUNT: sustain_amt = val[AMT_W-1:0];
        endcase
        cfg_writes++;
    endtask

    task automatic write_all(input logic [CFG_DATA_W-1:0] fp, input logic [CFG_DATA_W-1:0] sp,
                             input logic [CFG_DATA_W-1:0] aa, input logic [CFG_DATA_W-1:0] sa);
        cfg_write(CFG_FAST_COEFF, fp);
        cfg_write(CFG_SLOW_COEFF, sp);
        cfg_write(CFG_ATTACK_AMOUNT, aa);
        cfg_write(CFG_SUSTAIN_AMOUNT, sa);
        @(negedge i_clk);
    endtask

    task automatic push_req(input longint s, input int ch);
        request_q.push_back('{sample_in: SAMPLE_BITS'(s), channel: CH_W'(ch)});
        items_total++;
    endtask

    task automatic queue_random(input int n);
        int  left;
        int  len;
        int  mode;
        int  ch;
        t_in req;
        left = n;
        while (left > 0) begin
            ch   = $urandom_range(0, N_CH - 1);
            len  = $urandom_range(1, 24);
            mode = $urandom_range(0, 6);
            for (int j = 0; j < len && left > 0; j++) begin
                req.channel   = (mode == 6 || $urandom_range(0, 7) == 0) ? CH_W'($urandom)
                                                                          : CH_W'(ch);
                req.sample_in = pick_sample(mode, j);
                request_q.push_back(req);
                left--;
            end
        end
        items_total += n;
    endtask

    task automatic drain();
        while (items_accepted != items_total || shaped_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
        write_all(random_pole(), random_pole(), random_amount(), random_amount());
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        queue_random(n);
        drain();
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                shaped_q.push_back(predict_shaped(i_data));
                items_accepted++;
            end
            if (i_valid && !o_ready) begin
                i_valid <= 1'b1;
            end else if (request_q.size() != 0 && !tx_pause &&
                         $urandom_range(0, 99) >= tx_idle_pct) begin
                i_valid <= 1'b1;
                i_data  <= request_q.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (shaped_q.size() == 0) begin
                    $display("%0t: result with no request outstanding: sample %0d channel %0d",
                             $time, $signed(o_data.sample_out), o_data.channel_out);
                    errors++;
                end else begin
                    want = shaped_q.pop_front();
                    results_checked++;
                    if (o_data.sample_out !== want.sample_out) begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d", $time,
                                 $signed(want.sample_out), $signed(o_data.sample_out));
                        errors++;
                    end
                    if (o_data.channel_out !== want.channel_out) begin
                        $display("%0t: channel_out mismatch, expected %0d, got %0d", $time,
                                 want.channel_out, o_data.channel_out);
                        errors++;
                    end
                end
            end
            i_ready <= (rx_hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (rx_hold_left != 0) rx_hold_left <= rx_hold_left - 1;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     shaped_q.size());
            $display("dual_envelope_transient_shaper_tb: done, errors");
            $finish;
        end
    end

    initial begin
        for (int c = 0; c < N_CH; c++) begin
            fast_env[c] = '0;
            slow_env[c] = '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: unity gain
        push_req(S_MAX, 0);
        push_req(S_MIN, 0);
        push_req(0, 7);
        push_req(-1, 7);
        push_req(1, 3);
        push_req(S_MIN, 5);
        push_req(S_MAX, 5);
        drain();

        // instant fast follower, frozen slow one: strong boost, output saturates
        write_all(24'h000000, 24'hFFFFFF, 24'hFF7FFF, 24'h008000);
        push_req(S_MAX, 1);
        push_req(S_MAX, 1);
        push_req(0, 1);
        push_req(S_MIN, 2);
        push_req(-1, 2);
        push_req(1, 2);
        push_req(S_MAX, 6);
        push_req(S_MIN, 6);
        drain();

        // frozen fast follower, instant slow one: negative transient, full sustain
        write_all(24'hFFFFFF, 24'h000000, 24'h008000, 24'hFF7FFF);
        push_req(S_MIN, 4);
        push_req(S_MAX, 4);
        push_req(0, 4);
        push_req(S_MIN, 1);
        push_req(12345, 0);
        push_req(-1, 3);
        drain();

        run_phase(300, 0, 0);
        run_phase(300, 83, 0);
        run_phase(300, 0, 83);
        run_phase(300, 15, 15);

        // long receiver hold-off while requests keep coming
        write_all(random_pole(), random_pole(), random_amount(), random_amount());
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_left = 400;
        queue_random(200);
        drain();

        // sender pause until every result is back
        write_all(random_pole(), random_pole(), random_amount(), random_amount());
        tx_idle_pct  = 15;
        rx_stall_pct = 15;
        queue_random(300);
        while (items_accepted < items_total - 150) @(posedge i_clk);
        @(negedge i_clk);
        tx_pause = 1'b1;
        while (shaped_q.size() != 0 || i_valid) @(posedge i_clk);
        @(negedge i_clk);
        tx_pause = 1'b0;
        drain();

        write_all(24'h000000, 24'h000000, 24'h007FFF, 24'h008000);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        queue_random(150);
        drain();

        write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFF8000, 24'hFF7FFF);
        tx_idle_pct  = 15;
        rx_stall_pct = 15;
        queue_random(150);
        drain();

        $display("covered %0d requests and %0d checked results across %0d register writes",
                 items_accepted, results_checked, cfg_writes);
        $display("phases: directed, no idling, idle sender, stalling receiver, long hold-off, pause");
        if (errors == 0) begin
            $display("dual_envelope_transient_shaper_tb: done, clean");
        end else begin
            $display("dual_envelope_transient_shaper_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ dual_envelope_transient_shaper.f @@
rtl/dets_pkg.sv
rtl/dets_ram.sv
rtl/dets_mac.sv
rtl/dual_envelope_transient_shaper.sv
tb/dual_envelope_transient_shaper_tb.sv
